/* src/fcr_pkg.sv */
// Package for the floppy controller register block.
// Holds geometry constants, port and command codes, status bits and the result word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  // Disk geometry.
  localparam logic [7:0] NUM_TRACKS        = 8'd80;
  localparam logic [7:0] SECTORS_PER_TRACK = 8'd16;
  localparam logic [8:0] SECTOR_BYTES      = 9'd256;
  localparam logic [8:0] LAST_BYTE         = SECTOR_BYTES - 9'd1;

  localparam int unsigned MEDIA_ADDR_W = 20;
  localparam int unsigned DRIVES       = 4;

  // Port select codes.
  localparam logic [2:0] PORT_STATUS = 3'd0;
  localparam logic [2:0] PORT_TRACK  = 3'd1;
  localparam logic [2:0] PORT_SECTOR = 3'd2;
  localparam logic [2:0] PORT_DATA   = 3'd3;
  localparam logic [2:0] PORT_SYSTEM = 3'd4;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Command codes by upper nibble; read sector covers both 8 and 9.
  localparam logic [3:0] CMD_RESTORE     = 4'h0;
  localparam logic [3:0] CMD_SEEK        = 4'h1;
  localparam logic [2:0] CMD_READ_SECTOR = 3'b100;
  localparam logic [3:0] CMD_READ_ADDR   = 4'hC;

  // Status register values.
  localparam logic [7:0] ST_CLEAR    = 8'h00;
  localparam logic [7:0] ST_BUSY     = 8'h01;
  localparam logic [7:0] ST_INDEX    = 8'h02;
  localparam logic [7:0] ST_BUSY_DRQ = 8'h03;
  localparam logic [7:0] ST_TRACK0   = 8'h04;
  localparam logic [7:0] ST_SEEK_ERR = 8'h10;

  // System port read values.
  localparam logic [7:0] SYS_DRQ   = 8'h40;
  localparam logic [7:0] SYS_INTRQ = 8'h80;
  localparam logic [7:0] SYS_NONE  = 8'h00;

  // System write bits.
  localparam int unsigned SYS_RESET_BIT = 2;
  localparam int unsigned SYS_SIDE_BIT  = 4;

  localparam logic [2:0] ID_BYTES = 3'd6;

  typedef struct packed {
    logic [7:0]              read_data;
    logic [1:0]              media_drive;
    logic [MEDIA_ADDR_W-1:0] media_address;
    logic                    media_valid;
  } out_word_t;

endpackage

`default_nettype wire

/* src/fcr_if.sv */
// Handshake interfaces for the floppy controller register block.
// fcr_in_if carries one port access word, fcr_out_if one result word; uses fcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fcr_in_if import fcr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] port_sel;
  logic [7:0] write_data;
  logic [7:0] media_byte;

  modport source (output valid, output req_type, output port_sel, output write_data,
                  output media_byte, input ready);
  modport sink   (input valid, input req_type, input port_sel, input write_data,
                  input media_byte, output ready);
endinterface

interface fcr_out_if import fcr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [7:0]              read_data;
  logic [1:0]              media_drive;
  logic [MEDIA_ADDR_W-1:0] media_address;
  logic                    media_valid;

  modport source (output valid, output read_data, output media_drive, output media_address,
                  output media_valid, input ready);
  modport sink   (input valid, input read_data, input media_drive, input media_address,
                  input media_valid, output ready);
endinterface

`default_nettype wire

/* src/floppy_controller_registers.sv */
// Floppy controller register block: each accepted word's result is registered for output.
// Throughput: one word per cycle while input ready is high; the register update is a
// single combinational pass. A two-entry output stage (result register plus skid register)
// lets a new word enter while a finished result still waits; input ready drops only when
// both are full. Reset (rst_n, synchronous, active low) clears all controller registers,
// drives_present and the output valids.
`timescale 1ns / 1ps
`default_nettype none

module floppy_controller_registers import fcr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcr_in_if.sink     in_ch,
  fcr_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic [DRIVES-1:0] cfg_wdata
);

  logic [DRIVES-1:0] drives_present_r;
  logic [7:0] command_r, command_nxt;
  logic [7:0] status_r, status_nxt;
  logic [6:0] head_track_r, head_track_nxt;
  logic [6:0] req_track_r, req_track_nxt;
  logic [4:0] sector_r, sector_nxt;
  logic [7:0] data_r, data_nxt;
  logic [1:0] drive_r, drive_nxt;
  logic       side_r, side_nxt;
  logic [8:0] offset_r, offset_nxt;
  logic [2:0] id_cnt_r, id_cnt_nxt;

  logic      out_v_r, skid_v_r;
  out_word_t out_r, skid_r, res;

  logic       accept, pop;
  logic [7:0] rd;
  logic [7:0] sys_rd;
  logic       type1_cmd, rsec_cmd, raddr_cmd;
  logic       media_ok_cur;
  logic [4:0] sidx;
  logic [MEDIA_ADDR_W-1:0] block;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_v_r && out_ch.ready;

  assign type1_cmd = !command_r[7];
  assign rsec_cmd  = command_r[7:5] == CMD_READ_SECTOR;
  assign raddr_cmd = command_r[7:4] == CMD_READ_ADDR;

  assign media_ok_cur = (sector_r != 5'd0) && (offset_r < SECTOR_BYTES) &&
                        drives_present_r[drive_r];

  always_comb begin
    if (type1_cmd) begin
      sys_rd = SYS_INTRQ;
    end else if (raddr_cmd) begin
      sys_rd = (id_cnt_r < ID_BYTES) ? SYS_DRQ : SYS_INTRQ;
    end else if (rsec_cmd) begin
      sys_rd = (offset_r < SECTOR_BYTES) ? SYS_DRQ : SYS_INTRQ;
    end else begin
      sys_rd = SYS_NONE;
    end
  end

  // Next register values and read byte for the word at the input.
  always_comb begin
    command_nxt    = command_r;
    status_nxt     = status_r;
    head_track_nxt = head_track_r;
    req_track_nxt  = req_track_r;
    sector_nxt     = sector_r;
    data_nxt       = data_r;
    drive_nxt      = drive_r;
    side_nxt       = side_r;
    offset_nxt     = offset_r;
    id_cnt_nxt     = id_cnt_r;
    rd             = 8'd0;

    if (in_ch.req_type == REQ_WRITE) begin
      unique case (in_ch.port_sel)
        PORT_STATUS: begin
          command_nxt = in_ch.write_data;
          if (in_ch.write_data[7:4] == CMD_RESTORE) begin
            head_track_nxt = 7'd0;
            status_nxt     = ST_CLEAR;
          end else if (in_ch.write_data[7:4] == CMD_SEEK) begin
            if (data_r < NUM_TRACKS) begin
              head_track_nxt = data_r[6:0];
              req_track_nxt  = data_r[6:0];
              status_nxt     = (data_r[6:0] == 7'd0) ? ST_TRACK0 : ST_CLEAR;
            end else begin
              status_nxt = ST_SEEK_ERR;
            end
          end else if (in_ch.write_data[7:5] == CMD_READ_SECTOR) begin
            if (!drives_present_r[drive_r]) begin
              command_nxt = 8'd0;
            end
            offset_nxt = 9'd0;
          end else if (in_ch.write_data[7:4] == CMD_READ_ADDR) begin
            id_cnt_nxt = 3'd0;
          end
        end
        PORT_TRACK: begin
          if (in_ch.write_data <= NUM_TRACKS) begin
            req_track_nxt = in_ch.write_data[6:0];
          end
        end
        PORT_SECTOR: begin
          if (in_ch.write_data <= SECTORS_PER_TRACK) begin
            sector_nxt = in_ch.write_data[4:0];
          end
        end
        PORT_DATA: begin
          data_nxt = in_ch.write_data;
        end
        PORT_SYSTEM: begin
          drive_nxt  = in_ch.write_data[1:0];
          side_nxt   = !in_ch.write_data[SYS_SIDE_BIT];
          status_nxt = ST_CLEAR;
          // Controller reset keeps the drive select and the byte offset.
          if (in_ch.write_data[SYS_RESET_BIT]) begin
            sector_nxt     = 5'd0;
            side_nxt       = 1'b0;
            head_track_nxt = 7'd0;
            req_track_nxt  = 7'd0;
            data_nxt       = 8'd0;
            command_nxt    = 8'd0;
            status_nxt     = ST_CLEAR;
            id_cnt_nxt     = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (in_ch.port_sel)
        PORT_STATUS: begin
          // The index bit toggles on each status read while a type I command sits at track zero.
          if (type1_cmd && head_track_r == 7'd0) begin
            status_nxt = status_r ^ ST_INDEX;
          end
          rd = status_nxt;
        end
        PORT_TRACK:  rd = {1'b0, head_track_r};
        PORT_SECTOR: rd = {3'b000, sector_r};
        PORT_DATA: begin
          if (rsec_cmd) begin
            if (offset_r >= SECTOR_BYTES) begin
              status_nxt = ST_CLEAR;
              rd         = 8'd0;
            end else begin
              status_nxt = (offset_r == LAST_BYTE) ? ST_CLEAR : ST_BUSY;
              rd         = media_ok_cur ? in_ch.media_byte : 8'd0;
              offset_nxt = offset_r + 9'd1;
            end
          end else if (raddr_cmd) begin
            status_nxt = ST_BUSY_DRQ;
            if (id_cnt_r < ID_BYTES) begin
              id_cnt_nxt = id_cnt_r + 3'd1;
            end
            unique case (id_cnt_r)
              3'd0: rd = {1'b0, head_track_r};
              3'd1: rd = {7'd0, side_r};
              3'd2: rd = {3'b000, sector_r};
              3'd3: rd = 8'd1;
              3'd4: rd = 8'd0;
              3'd5: begin
                status_nxt = ST_CLEAR;
                rd         = 8'd0;
              end
              default: rd = sys_rd;
            endcase
          end else begin
            rd = sys_rd;
          end
        end
        PORT_SYSTEM: rd = sys_rd;
        default:     rd = 8'd0;
      endcase
    end
  end

  // Media address after this access; a zero sector counts as the first.
  assign sidx  = (sector_nxt != 5'd0) ? sector_nxt - 5'd1 : 5'd0;
  assign block = MEDIA_ADDR_W'({head_track_nxt, side_nxt}) * MEDIA_ADDR_W'(SECTORS_PER_TRACK)
                 + MEDIA_ADDR_W'(sidx);

  always_comb begin
    res.read_data     = rd;
    res.media_drive   = drive_nxt;
    res.media_address = block * MEDIA_ADDR_W'(SECTOR_BYTES) + MEDIA_ADDR_W'(offset_nxt);
    res.media_valid   = (sector_nxt != 5'd0) && (offset_nxt < SECTOR_BYTES) &&
                        drives_present_r[drive_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drives_present_r <= '0;
      command_r        <= '0;
      status_r         <= '0;
      head_track_r     <= '0;
      req_track_r      <= '0;
      sector_r         <= '0;
      data_r           <= '0;
      drive_r          <= '0;
      side_r           <= 1'b0;
      offset_r         <= '0;
      id_cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        drives_present_r <= cfg_wdata;
      end
      if (accept) begin
        command_r    <= command_nxt;
        status_r     <= status_nxt;
        head_track_r <= head_track_nxt;
        req_track_r  <= req_track_nxt;
        sector_r     <= sector_nxt;
        data_r       <= data_nxt;
        drive_r      <= drive_nxt;
        side_r       <= side_nxt;
        offset_r     <= offset_nxt;
        id_cnt_r     <= id_cnt_nxt;
      end
    end
  end

  // Output stage: the skid register catches a word when the result register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.read_data     = out_r.read_data;
  assign out_ch.media_drive   = out_r.media_drive;
  assign out_ch.media_address = out_r.media_address;
  assign out_ch.media_valid   = out_r.media_valid;

endmodule

`default_nettype wire
